// ===== sv/utt_pkg.sv =====
package utt_pkg;

   // Lead byte classes and masks.
   localparam logic [7:0] AsciiMax      = 8'h7F;
   localparam logic [7:0] ContMax       = 8'hBF;
   localparam logic [7:0] Lead2Max      = 8'hDF;
   localparam logic [7:0] Lead3Max      = 8'hEF;
   localparam logic [7:0] Lead4Max      = 8'hF7;
   localparam logic [7:0] ContMin       = 8'h80;
   localparam logic [4:0] Lead2Mask     = 5'h1F;
   localparam logic [3:0] Lead3Mask     = 4'h0F;
   localparam logic [2:0] Lead4Mask     = 3'h07;
   localparam logic [5:0] ContMask      = 6'h3F;

   // Code point limits.
   localparam logic [20:0] SurrogateLow  = 21'h00D800;
   localparam logic [20:0] SurrogateHigh = 21'h00DFFF;
   localparam logic [20:0] CodePointMax  = 21'h10FFFF;
   localparam logic [20:0] PlaneOneBase  = 21'h010000;
   localparam logic [15:0] HighSurrBase  = 16'hD800;
   localparam logic [15:0] LowSurrBase   = 16'hDC00;
   localparam logic [9:0]  SurrPayload   = 10'h3FF;

   // One decoded job handed from the front to the back.
   typedef struct packed {
      logic        pair;      // two units: high then low surrogate
      logic [15:0] unit0;     // single unit, or the high surrogate
      logic [15:0] unit1;     // low surrogate when pair is set
      logic        error;     // string failed; units are zero
      logic        eos;       // job closes the string
   } job_type;

   // Queue status seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== sv/utf8_to_utf16_transcoder_top.sv =====
// UTF-8 to UTF-16 transcoder. Each input word carries one UTF-8 byte in
// req_tdata and marks the final byte of a string with req_tlast. Each output
// word carries one UTF-16 code unit; code points above 0xFFFF come out as a
// high then a low surrogate in consecutive words. rsp_tuser[0] marks the last
// word caused by one input byte, rsp_tuser[1] flags an invalid string, and
// rsp_tlast marks the final word of a string. An invalid string (stray or bad
// continuation byte, lead byte above 0xF7, end in mid-sequence, surrogate
// value or value above 0x10FFFF) gives a single error word with a zero unit
// on its end byte; units already sent for it must be discarded. Overlong
// forms are accepted. The block takes one byte per cycle whenever its job
// queue has room, and delivers one word per cycle while the queue holds a
// job and the receiver is ready, so a surrogate pair takes two output words;
// the first word for a byte passes through the job queue and then the output
// register. The front decoder's state update sets the input rate, and the
// output register sets the output rate.
module utf8_to_utf16_transcoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] utf16_unit
   output logic [1:0]  rsp_tuser,    // [0] last_of_run, [1] error
   output logic        rsp_tlast     // string_end
);
   import utt_pkg::*;

   logic             push_valid;
   job_type          push_job;
   job_type          head_job;
   queue_status_type status;
   logic             pop;

   // The front decodes bytes and writes one job per code point or failed string.
   utt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (status.full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // The queue lets the decoder run on while the output side stalls.
   utt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (status)
   );

   // The back expands each job into one or two registered output words.
   utt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sv/utt_front.sv =====
module utt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   input  logic             queue_full,
   output logic             push_valid,
   output utt_pkg::job_type push_job
);
   import utt_pkg::*;

   logic [20:0] cp_ff, cp_in;
   logic [1:0]  rem_ff, rem_in;
   logic        failed_ff, failed_in;

   logic [20:0] cp_step;
   logic [1:0]  rem_step;
   logic        fail_step;
   logic        complete;
   logic        accept;
   logic [20:0] offset;
   logic        emit;
   job_type     job;

   assign accept     = req_tvalid && !queue_full;
   assign req_tready = !queue_full;

   // Decode one byte against the gathered state.
   always_comb begin
      cp_step   = cp_ff;
      rem_step  = rem_ff;
      fail_step = failed_ff;
      complete  = 1'b0;
      if (!failed_ff) begin
         if (rem_ff == 2'd0) begin
            if (req_tdata <= AsciiMax) begin
               cp_step  = {13'd0, req_tdata};
               complete = 1'b1;
            end else if (req_tdata <= ContMax) begin
               fail_step = 1'b1;
            end else if (req_tdata <= Lead2Max) begin
               cp_step  = {16'd0, req_tdata[4:0] & Lead2Mask};
               rem_step = 2'd1;
            end else if (req_tdata <= Lead3Max) begin
               cp_step  = {17'd0, req_tdata[3:0] & Lead3Mask};
               rem_step = 2'd2;
            end else if (req_tdata <= Lead4Max) begin
               cp_step  = {18'd0, req_tdata[2:0] & Lead4Mask};
               rem_step = 2'd3;
            end else begin
               fail_step = 1'b1;
            end
         end else if (req_tdata < ContMin || req_tdata > ContMax) begin
            fail_step = 1'b1;
         end else begin
            cp_step  = {cp_ff[14:0], req_tdata[5:0] & ContMask};
            rem_step = rem_ff - 2'd1;
            complete = (rem_step == 2'd0);
         end
         if (complete && ((cp_step >= SurrogateLow && cp_step <= SurrogateHigh)
                          || cp_step > CodePointMax)) begin
            fail_step = 1'b1;
            complete  = 1'b0;
         end
      end
   end

   assign offset = cp_step - PlaneOneBase;

   always_comb begin
      job.pair  = 1'b0;
      job.unit0 = cp_step[15:0];
      job.unit1 = LowSurrBase + {6'd0, offset[9:0] & SurrPayload};
      job.error = 1'b0;
      job.eos   = req_tlast;
      emit      = 1'b0;
      cp_in     = cp_step;
      rem_in    = rem_step;
      failed_in = fail_step;
      if (fail_step || !complete) begin
         // A failed string or one that ends mid-sequence gives a single error word.
         job.unit0 = 16'd0;
         job.unit1 = 16'd0;
         job.error = 1'b1;
         emit      = req_tlast;
         if (req_tlast) begin
            cp_in     = '0;
            rem_in    = '0;
            failed_in = 1'b0;
         end
      end else begin
         emit   = 1'b1;
         cp_in  = '0;
         rem_in = '0;
         if (cp_step > 21'h00FFFF) begin
            job.pair  = 1'b1;
            job.unit0 = HighSurrBase + {6'd0, offset[19:10]};
         end
      end
   end

   assign push_valid = accept && emit;
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff     <= '0;
         rem_ff    <= '0;
         failed_ff <= 1'b0;
      end else if (accept) begin
         cp_ff     <= cp_in;
         rem_ff    <= rem_in;
         failed_ff <= failed_in;
      end
   end

endmodule

// ===== sv/utt_queue.sv =====
module utt_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  utt_pkg::job_type         push_job,
   input  logic                     pop,
   output utt_pkg::job_type         head_job,
   output utt_pkg::queue_status_type status
);
   import utt_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   job_type               slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == CountWidth'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/utt_back.sv =====
module utt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  utt_pkg::job_type          head_job,
   input  utt_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,
   output logic [1:0]                rsp_tuser,
   output logic                      rsp_tlast
);
   import utt_pkg::*;

   logic        valid_ff, valid_in;
   logic        second_ff, second_in;
   logic [15:0] unit_ff, unit_in;
   logic [1:0]  user_ff, user_in;
   logic        last_ff, last_in;
   logic        load;

   assign load = !status.empty && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      second_in = second_ff;
      unit_in   = unit_ff;
      user_in   = user_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head_job.pair && !second_ff) begin
            // High surrogate: the job stays queued for its low half.
            unit_in   = head_job.unit0;
            user_in   = 2'b00;
            last_in   = 1'b0;
            second_in = 1'b1;
         end else begin
            unit_in   = head_job.pair ? head_job.unit1 : head_job.unit0;
            user_in   = {head_job.error, 1'b1};
            last_in   = head_job.eos;
            second_in = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = unit_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== tb/sv/utf8_to_utf16_transcoder_top_test.sv =====
module utf8_to_utf16_transcoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import utt_pkg::*;

   // Run shape. Idling stops once QuietAfter bytes have gone in, so the tail of
   // the run streams at full rate on both sides.
   localparam int StimBytes       = 1200;
   localparam int DrainPoint      = 600;
   localparam int QuietAfter      = 1000;
   localparam int LongStallStart  = 300;
   localparam int LongStallCycles = 400;
   localparam int SettleCycles    = 20;
   localparam int WatchdogLimit   = 4000;

   // One pending input word. A set wait_drain holds the word back until every
   // expected output word has been seen.
   typedef struct packed {
      logic [7:0] octet;
      logic       eos;
      logic       wait_drain;
   } octet_item_type;

   // One output word, with the fields in the order they are compared.
   typedef struct packed {
      logic [15:0] utf16_unit;
      logic        last_of_run;
      logic        error;
      logic        string_end;
   } utf16_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;     // [7:0] in_byte
   logic        req_tlast = 1'b0;      // end_of_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;             // [15:0] utf16_unit
   logic [1:0]  rsp_tuser;             // [0] last_of_run, [1] error
   logic        rsp_tlast;             // string_end

   octet_item_type octet_queue[$];
   utf16_word_type utf16_expected[$];

   // Decoder state kept by the testbench's own copy of the transcoder.
   logic [20:0] code_point = '0;
   logic [1:0]  cont_due = '0;
   logic        string_bad = 1'b0;

   int  error_count = 0;
   int  tx_count = 0;
   int  rx_count = 0;
   int  gap_left = 0;
   int  burst_left = 0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   bit  mark_drain = 1'b0;
   bit  drain_marked = 1'b0;
   bit  timed_out = 1'b0;

   utf8_to_utf16_transcoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Every input byte that the block accepts goes through here. It advances
   // the decoder state and queues the output words that the byte should cause.
   task automatic decode_octet(input logic [7:0] octet, input logic eos);
      logic        complete;
      logic [20:0] offset;
      complete = 1'b0;
      if (!string_bad) begin
         if (cont_due == 2'd0) begin
            if (octet <= AsciiMax) begin
               code_point = 21'(octet);
               complete = 1'b1;
            end else if (octet <= ContMax) begin
               // A continuation byte where a lead byte belongs.
               string_bad = 1'b1;
            end else if (octet <= Lead2Max) begin
               code_point = 21'(octet & Lead2Mask);
               cont_due = 2'd1;
            end else if (octet <= Lead3Max) begin
               code_point = 21'(octet & Lead3Mask);
               cont_due = 2'd2;
            end else if (octet <= Lead4Max) begin
               code_point = 21'(octet & Lead4Mask);
               cont_due = 2'd3;
            end else begin
               string_bad = 1'b1;
            end
         end else if (octet < ContMin || octet > ContMax) begin
            string_bad = 1'b1;
         end else begin
            code_point = {code_point[14:0], octet[5:0]};
            cont_due = cont_due - 2'd1;
            complete = (cont_due == 2'd0);
         end

         // Surrogate values and values past the top of the code space are
         // rejected even when the encoding itself is well formed.
         if (complete && ((code_point >= SurrogateLow && code_point <= SurrogateHigh) ||
                          code_point > CodePointMax)) begin
            string_bad = 1'b1;
            complete = 1'b0;
         end
      end

      if (string_bad || !complete) begin
         // A failed string, or one that stops in mid-sequence, closes with a
         // single error word on its end byte; other bytes stay silent.
         if (eos) begin
            utf16_expected.push_back({16'h0000, 1'b1, 1'b1, 1'b1});
            code_point = '0;
            cont_due = '0;
            string_bad = 1'b0;
         end
      end else begin
         if (code_point < PlaneOneBase) begin
            utf16_expected.push_back({code_point[15:0], 1'b1, 1'b0, eos});
         end else begin
            offset = code_point - PlaneOneBase;
            utf16_expected.push_back({HighSurrBase + 16'(offset[19:10]), 1'b0, 1'b0, 1'b0});
            utf16_expected.push_back({LowSurrBase + 16'(offset[9:0]), 1'b1, 1'b0, eos});
         end
         code_point = '0;
         cont_due = '0;
      end
   endtask

   task automatic add_octet(input logic [7:0] octet, input logic eos);
      octet_item_type item;
      item.octet = octet;
      item.eos = eos;
      item.wait_drain = mark_drain;
      mark_drain = 1'b0;
      octet_queue.push_back(item);
   endtask

   // One random string of one to six characters. Most characters are well
   // formed, with overlong forms left in on purpose; a few percent are broken
   // in one of the ways the decoder must catch.
   task automatic add_random_string();
      logic [7:0]  seq[$];
      logic [20:0] bits;
      int          n_chars;
      int          kind;
      n_chars = $urandom_range(1, 6);
      for (int i = 0; i < n_chars; i++) begin
         kind = $urandom_range(0, 99);
         bits = 21'($urandom);
         if (kind < 30) begin
            seq.push_back({1'b0, bits[6:0]});
         end else if (kind < 52) begin
            seq.push_back({3'b110, bits[10:6]});
            seq.push_back({2'b10, bits[5:0]});
         end else if (kind < 72) begin
            seq.push_back({4'b1110, bits[15:12]});
            seq.push_back({2'b10, bits[11:6]});
            seq.push_back({2'b10, bits[5:0]});
         end else if (kind < 92) begin
            bits = 21'($urandom_range(32'h10000, 32'h10FFFF));
            seq.push_back({5'b11110, bits[20:18]});
            seq.push_back({2'b10, bits[17:12]});
            seq.push_back({2'b10, bits[11:6]});
            seq.push_back({2'b10, bits[5:0]});
         end else begin
            case (kind)
               92: seq.push_back(8'($urandom_range(ContMin, ContMax)));
               93: seq.push_back(8'($urandom_range(32'hF8, 32'hFF)));
               94: begin
                  // Two-byte lead followed by something that is not a
                  // continuation byte.
                  seq.push_back({3'b110, bits[4:0]});
                  seq.push_back(bits[7] ? {2'b11, bits[13:8]} : {1'b0, bits[14:8]});
               end
               95: begin
                  seq.push_back(8'hED);
                  seq.push_back({3'b101, bits[4:0]});
                  seq.push_back({2'b10, bits[10:5]});
               end
               96: begin
                  seq.push_back(8'hF4);
                  seq.push_back(8'($urandom_range(32'h90, ContMax)));
                  seq.push_back({2'b10, bits[5:0]});
                  seq.push_back({2'b10, bits[11:6]});
               end
               97: begin
                  seq.push_back(8'($urandom_range(32'hF5, Lead4Max)));
                  seq.push_back({2'b10, bits[5:0]});
                  seq.push_back({2'b10, bits[11:6]});
                  seq.push_back({2'b10, bits[17:12]});
               end
               default: seq.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      // Now and then the string stops right after a lead byte.
      if ($urandom_range(0, 24) == 0)
         seq.push_back(8'($urandom_range(32'hC0, Lead4Max)));
      foreach (seq[j])
         add_octet(seq[j], j == seq.size() - 1);
   endtask

   // Sender. It holds one word on the bus until it is taken, then may go quiet
   // for a random burst. A word marked wait_drain is not offered until the
   // output side has caught up completely.
   always @(posedge clock) begin : drive_octets
      logic           valid_next;
      logic [7:0]     data_next;
      logic           last_next;
      octet_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         valid_next = req_tvalid;
         data_next = req_tdata;
         last_next = req_tlast;
         if (req_tvalid && req_tready) begin
            decode_octet(req_tdata, req_tlast);
            valid_next = 1'b0;
            if (tx_count < QuietAfter && (tx_count / 128) % 3 != 0 &&
                $urandom_range(0, 4) == 0)
               gap_left = $urandom_range(1, 12);
         end
         if (!valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (octet_queue.size() > 0 &&
                         !(octet_queue[0].wait_drain && utf16_expected.size() != 0)) begin
               item = octet_queue.pop_front();
               valid_next = 1'b1;
               data_next = item.octet;
               last_next = item.eos;
            end
         end
         // Exactly one nonblocking update per output signal per edge.
         req_tvalid <= valid_next;
         req_tdata <= data_next;
         req_tlast <= last_next;
         if (req_tvalid && req_tready)
            tx_count <= tx_count + 1;
      end
   end

   // Receiver. Every word taken is checked against the oldest expected word.
   // Ready drops in random bursts, and once, after LongStallStart words, it
   // stays low long enough for the block's queue to fill and push back.
   always @(posedge clock) begin : check_words
      utf16_word_type seen;
      utf16_word_type want;
      logic           ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast};
            if (utf16_expected.size() == 0) begin
               report_error($sformatf("word %0d not expected: unit %h user %b last %b",
                                      rx_count, rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = utf16_expected.pop_front();
               if (seen.utf16_unit !== want.utf16_unit)
                  report_error($sformatf("word %0d utf16_unit: got %h, expected %h",
                                         rx_count, seen.utf16_unit, want.utf16_unit));
               if (seen.last_of_run !== want.last_of_run)
                  report_error($sformatf("word %0d last_of_run: got %b, expected %b",
                                         rx_count, seen.last_of_run, want.last_of_run));
               if (seen.error !== want.error)
                  report_error($sformatf("word %0d error: got %b, expected %b",
                                         rx_count, seen.error, want.error));
               if (seen.string_end !== want.string_end)
                  report_error($sformatf("word %0d string_end: got %b, expected %b",
                                         rx_count, seen.string_end, want.string_end));
            end
            rx_count++;
            if (rx_count == LongStallStart)
               stall_left = LongStallCycles;
         end

         ready_next = 1'b1;
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            ready_next = 1'b0;
         end else if (tx_count < QuietAfter && (rx_count / 100) % 3 != 1 &&
                      $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 11);
            ready_next = 1'b0;
         end
         rsp_tready <= ready_next;
      end
   end

   // Cycles in a row with no word taken on either side.
   always @(posedge clock) begin
      if (reset)
         idle_cycles <= 0;
      else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      // Directed strings first: the lowest and highest one-byte values, a two-byte
      // and a three-byte character, a surrogate pair, the top value, and one string for each way a string can fail.
      add_octet(8'h00, 1'b0);
      add_octet(8'h7F, 1'b1);
      add_octet(8'hC2, 1'b0);                       // U+00A9
      add_octet(8'hA9, 1'b0);
      add_octet(8'hE2, 1'b0);                       // U+20AC
      add_octet(8'h82, 1'b0);
      add_octet(8'hAC, 1'b1);
      add_octet(8'hF0, 1'b0);                       // U+1F600, a surrogate pair
      add_octet(8'h9F, 1'b0);
      add_octet(8'h98, 1'b0);
      add_octet(8'h80, 1'b1);
      add_octet(8'hF4, 1'b0);                       // U+10FFFF, the top value
      add_octet(8'h8F, 1'b0);
      add_octet(8'hBF, 1'b0);
      add_octet(8'hBF, 1'b1);
      add_octet(8'h80, 1'b1);                       // stray continuation byte
      add_octet(8'hFF, 1'b1);                       // lead byte above 0xF7
      add_octet(8'hC3, 1'b0);                       // bad continuation byte,
      add_octet(8'h41, 1'b0);                       // then silent bytes
      add_octet(8'h42, 1'b1);
      add_octet(8'hE2, 1'b0);                       // ends in mid-sequence
      add_octet(8'h82, 1'b1);
      add_octet(8'hED, 1'b0);                       // encodes a surrogate value
      add_octet(8'hA0, 1'b0);
      add_octet(8'h80, 1'b1);
      add_octet(8'hF4, 1'b0);                       // above 0x10FFFF
      add_octet(8'h90, 1'b0);
      add_octet(8'h80, 1'b0);
      add_octet(8'h80, 1'b1);

      // Random strings. Halfway through, the sender pauses once until every
      // expected word has been delivered.
      while (octet_queue.size() < StimBytes) begin
         if (!drain_marked && octet_queue.size() >= DrainPoint) begin
            mark_drain = 1'b1;
            drain_marked = 1'b1;
         end
         add_random_string();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            while (!(octet_queue.size() == 0 && !req_tvalid && utf16_expected.size() == 0))
               @(posedge clock);
            repeat (SettleCycles) @(posedge clock);
         end
         begin
            while (idle_cycles < WatchdogLimit)
               @(posedge clock);
            timed_out = 1'b1;
         end
      join_any

      if (timed_out)
         $display("utf8_to_utf16_transcoder_top_test: done, errors");
      else if (error_count == 0)
         $display("utf8_to_utf16_transcoder_top_test: done, clean");
      else
         $display("utf8_to_utf16_transcoder_top_test: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
sv/utt_pkg.sv
sv/utt_front.sv
sv/utt_queue.sv
sv/utt_back.sv
sv/utf8_to_utf16_transcoder_top.sv
tb/sv/utf8_to_utf16_transcoder_top_test.sv
